/* hw/rtl/sbm_pkg.sv */
// shared types and constants for the size-by-mode calculator
// no dependencies
package sbm_pkg;
   typedef enum logic [2:0] {
      FUNC_EXACT = 3'd0, FUNC_ADD = 3'd1, FUNC_DIAG = 3'd2, FUNC_DIV = 3'd3,
      FUNC_MUL = 3'd4, FUNC_ROW = 3'd5, FUNC_COL = 3'd6, FUNC_BAD = 3'd7
   } func_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_BAD_MODE = 2'd1, ST_BAD_SIZE = 2'd2
   } status_type;
   localparam int OUT_W = 31;
   localparam int RES_W = 48;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
   typedef struct packed {
      logic bad;
      logic div_zero;
   } lane_flag_type;
endpackage

/* hw/rtl/sbm_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on sbm_pkg
module sbm_isqrt import sbm_pkg::*; #(
   parameter int IN_W = 34
) (
   input  logic               clock,
   input  logic [IN_W-1:0]    op_in,
   output logic [IN_W/2-1:0]  root
);
   localparam int RW = IN_W / 2;
   logic [IN_W-1:0] rem_ff  [RW+1];
   logic [IN_W-1:0] val_ff  [RW+1];
   logic [RW-1:0]   res_ff  [RW+1];

   assign rem_ff[0] = '0;
   assign val_ff[0] = op_in;
   assign res_ff[0] = '0;

   // restoring square root, two operand bits per stage
   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic [IN_W+1:0] rem_in;
      logic [IN_W+1:0] trial_in;
      always_comb begin
         rem_in   = {rem_ff[s], val_ff[s][IN_W-1:IN_W-2]};
         trial_in = {{(IN_W-RW){1'b0}}, res_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         val_ff[s+1] <= {val_ff[s][IN_W-3:0], 2'b00};
         if (rem_in >= trial_in) begin
            rem_ff[s+1] <= IN_W'(rem_in - trial_in);
            res_ff[s+1] <= {res_ff[s][RW-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= IN_W'(rem_in);
            res_ff[s+1] <= {res_ff[s][RW-2:0], 1'b0};
         end
      end
   end
   assign root = res_ff[RW];
endmodule

/* hw/rtl/sbm_divider.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on sbm_pkg
module sbm_divider import sbm_pkg::*; #(
   parameter int N_W = 16,
   parameter int D_W = 16
) (
   input  logic           clock,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [N_W-1:0] quo
);
   logic [D_W:0]   rem_ff [N_W+1];
   logic [N_W-1:0] num_ff [N_W+1];
   logic [N_W-1:0] quo_ff [N_W+1];
   logic [D_W-1:0] den_ff [N_W+1];

   assign rem_ff[0] = '0;
   assign num_ff[0] = num;
   assign quo_ff[0] = '0;
   assign den_ff[0] = den;

   for (genvar s = 0; s < N_W; s++) begin : g_stage
      logic [D_W+1:0] rem_in;
      always_comb rem_in = {rem_ff[s], num_ff[s][N_W-1]};
      always_ff @(posedge clock) begin
         num_ff[s+1] <= num_ff[s] << 1;
         den_ff[s+1] <= den_ff[s];
         if (rem_in >= {2'b00, den_ff[s]}) begin
            rem_ff[s+1] <= (D_W+1)'(rem_in - {2'b00, den_ff[s]});
            quo_ff[s+1] <= {quo_ff[s][N_W-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= (D_W+1)'(rem_in);
            quo_ff[s+1] <= {quo_ff[s][N_W-2:0], 1'b0};
         end
      end
   end
   assign quo = quo_ff[N_W];
endmodule

/* hw/rtl/sbm_lane.sv */
// one dimension lane: pass-through, add, multiply and divide, delayed to common depth
// depends on sbm_pkg, sbm_divider
module sbm_lane import sbm_pkg::*; #(
   parameter int DIM_WIDTH   = 16,
   parameter int PARAM_WIDTH = 16,
   parameter int DEPTH       = 18,
   parameter int LANE        = 0
) (
   input  logic                          clock,
   input  func_type                      func,
   input  logic [DIM_WIDTH-1:0]          dim,
   input  logic signed [PARAM_WIDTH-1:0] param,
   output logic signed [RES_W-1:0]       res,
   output lane_flag_type                 flag
);
   logic [DIM_WIDTH-1:0]          quo;
   logic [PARAM_WIDTH-1:0]        den_mag;
   logic signed [RES_W-1:0]       early_in;
   logic                          is_div;
   logic                          add_sel;
   logic signed [DIM_WIDTH+PARAM_WIDTH:0] prod_in;
   logic signed [RES_W-1:0]       early_ff [DEPTH];
   logic [DEPTH-1:0]              div_ff;
   logic [DEPTH-1:0]              neg_ff;
   logic [DEPTH-1:0]              zero_ff;

   assign den_mag = param[PARAM_WIDTH-1] ? PARAM_WIDTH'(-param) : param;

   sbm_divider #(.N_W(DIM_WIDTH), .D_W(PARAM_WIDTH)) u_div (
      .clock(clock), .num(dim), .den(den_mag), .quo(quo)
   );

   // non-divide lane result; lane 0 is x, 1 is y, 2 is z
   always_comb begin
      is_div  = (func == FUNC_DIV);
      add_sel = (func == FUNC_ADD) ||
                (func == FUNC_DIAG && LANE == 2) ||
                (func == FUNC_ROW && LANE == 1) ||
                (func == FUNC_COL && LANE == 0);
      prod_in = $signed({1'b0, dim}) * param;
      if (add_sel) begin
         early_in = RES_W'($signed({1'b0, dim})) + RES_W'(param);
      end else if (func == FUNC_MUL) begin
         early_in = RES_W'(prod_in);
      end else begin
         early_in = RES_W'(param);
      end
   end

   // delay line matching the depth of the divider and its quotient tail
   always_ff @(posedge clock) begin
      early_ff[0] <= early_in;
      for (int i = 1; i < DEPTH; i++) early_ff[i] <= early_ff[i-1];
      div_ff  <= {div_ff[DEPTH-2:0], is_div};
      neg_ff  <= {neg_ff[DEPTH-2:0], param[PARAM_WIDTH-1]};
      zero_ff <= {zero_ff[DEPTH-2:0], param == '0};
   end

   // tail of the divider is DIM_WIDTH deep; delay quotient to DEPTH
   logic [DIM_WIDTH-1:0] quo_ff [DEPTH-DIM_WIDTH];
   always_ff @(posedge clock) begin
      quo_ff[0] <= quo;
      for (int i = 1; i < DEPTH - DIM_WIDTH; i++) quo_ff[i] <= quo_ff[i-1];
   end

   always_comb begin
      flag.div_zero = div_ff[DEPTH-1] & zero_ff[DEPTH-1];
      if (div_ff[DEPTH-1]) begin
         res = neg_ff[DEPTH-1] ? -RES_W'($signed({1'b0, quo_ff[DEPTH-DIM_WIDTH-1]}))
                               : RES_W'($signed({1'b0, quo_ff[DEPTH-DIM_WIDTH-1]}));
      end else begin
         res = early_ff[DEPTH-1];
      end
      flag.bad = (res <= 0);
   end
endmodule

/* hw/rtl/size_by_mode_calculator_unit.sv */
// top level: three dimension lanes, a square root unit and a merge stage
// depends on sbm_pkg, sbm_lane, sbm_isqrt
// the result strobe follows the accepting edge through the square root and divider pipes,
// their delay lines and the merge stage output register
// one transfer per cycle; busy is always low
// synchronous reset clears the valid pipe; the receiver cannot stall
module size_by_mode_calculator_unit import sbm_pkg::*; #(
   parameter int DIM_WIDTH   = 16,
   parameter int PARAM_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_func,
   input  logic [DIM_WIDTH-1:0]          req_ref_width,
   input  logic [DIM_WIDTH-1:0]          req_ref_height,
   input  logic [DIM_WIDTH-1:0]          req_ref_depth,
   input  logic signed [PARAM_WIDTH-1:0] req_param_x,
   input  logic signed [PARAM_WIDTH-1:0] req_param_y,
   input  logic signed [PARAM_WIDTH-1:0] req_param_z,
   output logic                          rsp_valid,
   output logic [OUT_W-1:0]              rsp_out_x,
   output logic [OUT_W-1:0]              rsp_out_y,
   output logic [OUT_W-1:0]              rsp_out_z,
   output logic [1:0]                    rsp_status
);

   localparam int SQ_W  = 2 * DIM_WIDTH + 2;
   localparam int RT_W  = SQ_W / 2;
   localparam int DEPTH = RT_W + 1;

   logic [SQ_W-1:0]         sq_in;
   logic [2*DIM_WIDTH-1:0]  wsq_in;
   logic [2*DIM_WIDTH-1:0]  hsq_in;
   logic [RT_W-1:0]         root;
   logic signed [RES_W-1:0] res [3];
   lane_flag_type           flag [3];
   logic [DEPTH-1:0]        vld_ff;
   func_type                func_ff [DEPTH];
   logic signed [PARAM_WIDTH-1:0] py_ff [DEPTH];

   assign busy = 1'b0;

   // sum of squares, registered in front of the root pipe's first stage input
   logic [SQ_W-1:0] sq_ff;
   assign wsq_in = req_ref_width * req_ref_width;
   assign hsq_in = req_ref_height * req_ref_height;
   assign sq_in  = SQ_W'(wsq_in) + SQ_W'(hsq_in);
   always_ff @(posedge clock) sq_ff <= sq_in;

   sbm_isqrt #(.IN_W(SQ_W)) u_sqrt (.clock(clock), .op_in(sq_ff), .root(root));

   sbm_lane #(.DIM_WIDTH(DIM_WIDTH), .PARAM_WIDTH(PARAM_WIDTH), .DEPTH(DEPTH),
         .LANE(0)) u_lx (
      .clock(clock), .func(func_type'(req_func)), .dim(req_ref_width),
      .param(req_param_x), .res(res[0]), .flag(flag[0]));
   sbm_lane #(.DIM_WIDTH(DIM_WIDTH), .PARAM_WIDTH(PARAM_WIDTH), .DEPTH(DEPTH),
         .LANE(1)) u_ly (
      .clock(clock), .func(func_type'(req_func)), .dim(req_ref_height),
      .param(req_param_y), .res(res[1]), .flag(flag[1]));
   sbm_lane #(.DIM_WIDTH(DIM_WIDTH), .PARAM_WIDTH(PARAM_WIDTH), .DEPTH(DEPTH),
         .LANE(2)) u_lz (
      .clock(clock), .func(func_type'(req_func)), .dim(req_ref_depth),
      .param(req_param_z), .res(res[2]), .flag(flag[2]));

   // control pipe
   always_ff @(posedge clock) begin
      func_ff[0] <= func_type'(req_func);
      py_ff[0]   <= req_param_y;
      for (int i = 1; i < DEPTH; i++) begin
         func_ff[i] <= func_ff[i-1];
         py_ff[i]   <= py_ff[i-1];
      end
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[DEPTH-2:0], start};
   end

   // merge stage
   logic signed [RES_W-1:0] r_in [3];
   logic signed [RES_W-1:0] dy;
   status_type              st_in;
   always_comb begin
      r_in[0] = res[0];
      r_in[1] = res[1];
      r_in[2] = res[2];
      dy = RES_W'($signed({1'b0, root})) + RES_W'(py_ff[DEPTH-1]);
      if (func_ff[DEPTH-1] == FUNC_DIAG) begin
         r_in[1] = (dy > 0) ? {dy[RES_W-1:1], 1'b0} : dy;
      end
      if (func_ff[DEPTH-1] == FUNC_BAD) st_in = ST_BAD_MODE;
      else if (flag[0].div_zero | flag[1].div_zero | flag[2].div_zero) st_in = ST_BAD_SIZE;
      else if (r_in[0] <= 0 || r_in[1] <= 0 || r_in[2] <= 0) st_in = ST_BAD_SIZE;
      else st_in = ST_OK;
   end

   logic [OUT_W-1:0] ox_ff, oy_ff, oz_ff;
   logic [1:0]       st_ff;
   logic             rv_ff;
   function automatic logic [OUT_W-1:0] sat(input logic signed [RES_W-1:0] v);
      if (v > RES_W'({1'b0, OUT_MAX})) return OUT_MAX;
      return v[OUT_W-1:0];
   endfunction
   always_ff @(posedge clock) begin
      ox_ff <= (st_in == ST_OK) ? sat(r_in[0]) : '0;
      oy_ff <= (st_in == ST_OK) ? sat(r_in[1]) : '0;
      oz_ff <= (st_in == ST_OK) ? sat(r_in[2]) : '0;
      st_ff <= st_in;
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= vld_ff[DEPTH-1];
   end

   assign rsp_valid  = rv_ff;
   assign rsp_out_x  = ox_ff;
   assign rsp_out_y  = oy_ff;
   assign rsp_out_z  = oz_ff;
   assign rsp_status = st_ff;

`ifndef ASSERT_OFF
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status code");
   a_zero_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_x == '0 && rsp_out_y == '0)
      else $error("nonzero output on error");
   a_ok_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_out_x != '0 && rsp_out_z != '0)
      else $error("zero output with ok status");
`endif
endmodule

/* verif/sbm_checker.sv */
// checker for the size-by-mode calculator: watches request and response transfers,
// predicts each response and compares all its fields; depends on sbm_pkg
`timescale 1ns / 1ps
module sbm_checker import sbm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [2:0]        req_func,
   input  logic [15:0]       req_ref_width,
   input  logic [15:0]       req_ref_height,
   input  logic [15:0]       req_ref_depth,
   input  logic signed [15:0] req_param_x,
   input  logic signed [15:0] req_param_y,
   input  logic signed [15:0] req_param_z,
   input  logic              rsp_valid,
   input  logic [OUT_W-1:0]  rsp_out_x,
   input  logic [OUT_W-1:0]  rsp_out_y,
   input  logic [OUT_W-1:0]  rsp_out_z,
   input  logic [1:0]        rsp_status,
   output int                errors,
   output int                pending
);
   typedef struct packed {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic [OUT_W-1:0] z;
      logic [1:0]       st;
   } size_result_type;

   size_result_type size_queue[$];

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic size_result_type calc_size(logic [2:0] f, logic [15:0] w16,
         logic [15:0] h16, logic [15:0] d16, logic signed [15:0] a,
         logic signed [15:0] b, logic signed [15:0] c);
      longint w, h, d, p0, p1, p2, yd;
      longint r[3];
      status_type st;
      size_result_type res;
      w = w16; h = h16; d = d16;
      p0 = a; p1 = b; p2 = c;
      st = ST_OK;
      r[0] = 0; r[1] = 0; r[2] = 0;
      case (func_type'(f))
         FUNC_EXACT: begin r[0] = p0; r[1] = p1; r[2] = p2; end
         FUNC_ADD: begin r[0] = w + p0; r[1] = h + p1; r[2] = d + p2; end
         FUNC_DIAG: begin
            yd = longint'(int_sqrt(w * w + h * h)) + p1;
            if (yd > 0) yd = yd - (yd & 1);
            r[0] = p0; r[1] = yd; r[2] = d + p2;
         end
         FUNC_DIV: begin
            if (p0 == 0 || p1 == 0 || p2 == 0) st = ST_BAD_SIZE;
            else begin r[0] = w / p0; r[1] = h / p1; r[2] = d / p2; end
         end
         FUNC_MUL: begin r[0] = w * p0; r[1] = h * p1; r[2] = d * p2; end
         FUNC_ROW: begin r[0] = p0; r[1] = h + p1; r[2] = p2; end
         FUNC_COL: begin r[0] = w + p0; r[1] = p1; r[2] = p2; end
         default: st = ST_BAD_MODE;
      endcase
      if (st == ST_OK)
         for (int j = 0; j < 3; j++) begin
            if (r[j] <= 0) st = ST_BAD_SIZE;
            else if (r[j] > 64'h7FFFFFFF) r[j] = 64'h7FFFFFFF;
         end
      res.x = (st == ST_OK) ? r[0][OUT_W-1:0] : '0;
      res.y = (st == ST_OK) ? r[1][OUT_W-1:0] : '0;
      res.z = (st == ST_OK) ? r[2][OUT_W-1:0] : '0;
      res.st = st;
      return res;
   endfunction

   assign pending = size_queue.size();

   // predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      size_result_type exp_res, got;
      if (reset) begin
         errors <= 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_status};
            if (size_queue.size() == 0) begin
               if (errors < 10) $display("unexpected response %h", got);
               errors <= errors + 1;
            end else begin
               exp_res = size_queue.pop_front();
               if (got !== exp_res) begin
                  if (errors < 10)
                     $display("mismatch: exp x=%0d y=%0d z=%0d st=%0d got x=%0d y=%0d z=%0d st=%0d",
                        exp_res.x, exp_res.y, exp_res.z, exp_res.st,
                        got.x, got.y, got.z, got.st);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy)
            size_queue.push_back(calc_size(req_func, req_ref_width, req_ref_height,
               req_ref_depth, req_param_x, req_param_y, req_param_z));
      end
   end
endmodule

/* verif/tb.sv */
// testbench top for the size-by-mode calculator: clock, reset, stimulus, verdict
// depends on sbm_pkg, sbm_checker and size_by_mode_calculator_unit
`timescale 1ns / 1ps
module tb;
   import sbm_pkg::*;

   logic clock = 0, reset = 1, start = 0, busy;
   logic [2:0] req_func = '0;
   logic [15:0] req_ref_width = '0, req_ref_height = '0, req_ref_depth = '0;
   logic signed [15:0] req_param_x = '0, req_param_y = '0, req_param_z = '0;
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [1:0] rsp_status;
   int errors, pending;

   always #5 clock = ~clock;

   size_by_mode_calculator_unit dut (.*);
   sbm_checker chk (.*);

   // random dimension: half the time small, a quarter near the top, else fully random
   function automatic logic [15:0] rand_dim();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 20));
         1: return 16'($urandom_range(0, 255));
         2: return 16'($urandom_range(65500, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_param();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 10) - 5);
         1: return 16'($urandom_range(1, 300));
         2: return 16'(16'h8000 + $urandom_range(0, 3));
         3: return 16'(16'h7FFF - $urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // one request transfer, then optional idle burst
   task automatic send(logic [2:0] f, logic [15:0] w, logic [15:0] h, logic [15:0] d,
         logic [15:0] a, logic [15:0] b, logic [15:0] c, bit idle);
      req_func <= f; req_ref_width <= w; req_ref_height <= h; req_ref_depth <= d;
      req_param_x <= a; req_param_y <= b; req_param_z <= c;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (idle && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   initial begin
      int wait_cnt;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed part
      send(FUNC_EXACT, 0, 0, 0, 1, 1, 1, 0);
      send(FUNC_EXACT, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send(FUNC_EXACT, 0, 0, 0, 16'h8000, 1, 1, 0);
      send(FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send(FUNC_ADD, 5, 5, 5, -5, 1, 1, 0);
      send(FUNC_DIAG, 16'hFFFF, 16'hFFFF, 1, 1, 0, 0, 0);
      send(FUNC_DIAG, 3, 4, 1, 1, 0, 1, 0);
      send(FUNC_DIAG, 1, 0, 1, 1, 0, 0, 0);
      send(FUNC_DIAG, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0);
      send(FUNC_DIV, 16'hFFFF, 7, 100, 1, 2, -3, 0);
      send(FUNC_DIV, 10, 10, 10, 3, 0, 2, 0);
      send(FUNC_DIV, 10, 10, 10, 16'h8000, 16'h8000, 16'h8000, 0);
      send(FUNC_DIV, 1, 1, 1, 2, 1, 1, 0);
      send(FUNC_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send(FUNC_MUL, 16'hFFFF, 2, 2, 16'h8000, 1, 1, 0);
      send(FUNC_MUL, 0, 1, 1, 5, 5, 5, 0);
      send(FUNC_ROW, 0, 16'hFFFF, 0, 1, 16'h7FFF, 1, 0);
      send(FUNC_COL, 16'hFFFF, 0, 0, 16'h7FFF, 1, 1, 0);
      send(FUNC_COL, 0, 0, 0, 0, 1, 1, 0);
      send(FUNC_BAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      // random part, idle bursts except in the final stretch
      for (int i = 0; i < 1750; i++)
         send(3'($urandom_range(0, 7)), rand_dim(), rand_dim(), rand_dim(),
            rand_param(), rand_param(), rand_param(), i < 1500);
      start <= 0;
      wait_cnt = 0;
      while (pending != 0 && wait_cnt < 10000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule
